// File: hdl/pwrv_pkg.sv
// Package for the per-pixel weighted running variance block.
// Holds image geometry, field widths and the status struct; no dependencies.
package pwrv_pkg;
    localparam int IMAGE_WIDTH  = 256;
    localparam int IMAGE_HEIGHT = 256;
    localparam int ADDR_W  = 16;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int W_RAD   = 40;
    localparam int W_MEAN  = 32;
    localparam int W_SPR   = 48;
    localparam int W_WGT   = 40;
    localparam int W_DIV   = 72;
    // Bits of one pixel entry: three radiance, three mean, three spread, one weight.
    localparam int ENTRY_W = 3 * W_RAD + 3 * W_MEAN + 3 * W_SPR + W_WGT;

    typedef struct packed {
        logic [W_RAD-1:0]  rad;
        logic [W_MEAN-1:0] mean;
        logic [W_SPR-1:0]  spr;
    } t_chan;

    typedef struct packed {
        t_chan [2:0]      ch;
        logic [W_WGT-1:0] wgt;
    } t_entry;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

    // Column or row from a Q0.16 fraction, clamped to the last one.
    function automatic logic [ADDR_W-1:0] pick_coord(input logic [15:0] frac,
                                                     input int size);
        logic [31:0] c;
        c = (32'(frac) * 32'(size)) >> 16;
        if (c > 32'(size - 1)) c = 32'(size - 1);
        return c[ADDR_W-1:0];
    endfunction
endpackage

// File: hdl/pwrv_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module pwrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hdl/pwrv_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pwrv_pkg for widths and the control struct.
module pwrv_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pwrv_pkg::W_DIV-1:0] i_num,
    input  logic [pwrv_pkg::W_WGT-1:0] i_den,
    output pwrv_pkg::t_div_ctl        o_ctl,
    output logic [pwrv_pkg::W_DIV-1:0] o_quo
);
    localparam int CW = $clog2(pwrv_pkg::W_DIV + 1);
    logic [pwrv_pkg::W_DIV-1:0] r_q;
    logic [pwrv_pkg::W_WGT:0]   r_rem;
    logic [pwrv_pkg::W_WGT-1:0] r_den;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy, r_done;
    logic [pwrv_pkg::W_WGT:0]   n_trial;

    assign n_trial = {r_rem[pwrv_pkg::W_WGT-1:0], r_q[pwrv_pkg::W_DIV-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(pwrv_pkg::W_DIV);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (n_trial >= {1'b0, r_den}) begin
                r_rem <= n_trial - {1'b0, r_den};
                r_q   <= {r_q[pwrv_pkg::W_DIV-2:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_q   <= {r_q[pwrv_pkg::W_DIV-2:0], 1'b0};
            end
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quo = r_q;
endmodule

// File: hdl/pixel_weighted_running_variance.sv
// Per-pixel weighted running mean and spread, West's incremental rule.
// Steps: read; per colour channel a difference, bit-serial division, multiplies and update;
// then write-back and hand-off. Division and multiplies are skipped when the new weight sum
// is zero. A new input is taken only once the last result is in the output register; a
// waiting result holds the block only once the next item is finished.
// Reset: synchronous, active low; then a clearing pass over all 65536 entries, no input taken meanwhile.
module pixel_weighted_running_variance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sample_u,
    input  logic [15:0] i_sample_v,
    input  logic [31:0] i_weight,
    input  logic [31:0] i_value_r,
    input  logic [31:0] i_value_g,
    input  logic [31:0] i_value_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_index,
    output logic [39:0] o_radiance_r,
    output logic [39:0] o_radiance_g,
    output logic [39:0] o_radiance_b,
    output logic [31:0] o_average_r,
    output logic [31:0] o_average_g,
    output logic [31:0] o_average_b,
    output logic [47:0] o_spread_r,
    output logic [47:0] o_spread_g,
    output logic [47:0] o_spread_b,
    output logic [39:0] o_total_weight
);
    localparam int AW = pwrv_pkg::ADDR_W;

    // One-hot sequencer. Each channel runs DIFF (difference, divider start), DIV, MUL1
    // (|d|*|R|), MUL2 (times old weight, split in parts) and UPD; a zero new sum skips to UPD.
    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_READ  = 11'b00000000100,
        S_DIFF  = 11'b00000001000,
        S_DIV   = 11'b00000010000,
        S_MUL1  = 11'b00000100000,
        S_MUL2A = 11'b00001000000,
        S_MUL2B = 11'b00010000000,
        S_UPD   = 11'b00100000000,
        S_WRITE = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_addr, r_clr;
    logic [31:0]   r_w;
    logic [31:0]   r_val [3];
    logic [1:0]    r_ch;
    pwrv_pkg::t_entry r_ent, w_rd;
    logic [pwrv_pkg::W_WGT-1:0] r_snew;
    logic        r_neg;
    logic [31:0] r_ad, r_ar;
    logic [63:0] r_dr;
    logic [63:0] r_plo, r_phi;
    logic [71:0] r_pmh;
    logic        r_ovalid;
    logic [AW-1:0]    r_opix;
    pwrv_pkg::t_entry r_oent;

    logic        w_we;
    logic [AW-1:0] w_maddr;
    pwrv_pkg::t_entry w_wdata;
    pwrv_pkg::t_div_ctl w_dctl;
    logic [pwrv_pkg::W_DIV-1:0] w_quo;
    logic [31:0] w_x, w_y;
    logic [31:0] w_idx;
    logic [40:0] w_ssum;
    logic [31:0] w_m, w_v;
    logic [31:0] w_ad;
    logic [63:0] w_dnum;
    logic        w_load;

    assign o_ready = (r_state == S_IDLE);
    assign w_x = 32'(pwrv_pkg::pick_coord(i_sample_u, pwrv_pkg::IMAGE_WIDTH));
    assign w_y = 32'(pwrv_pkg::pick_coord(i_sample_v, pwrv_pkg::IMAGE_HEIGHT));
    assign w_idx = w_y * 32'(pwrv_pkg::IMAGE_WIDTH) + w_x;
    assign w_ssum = {1'b0, w_rd.wgt} + 41'(r_w);
    assign w_m = r_ent.ch[r_ch].mean;
    assign w_v = r_val[r_ch];
    // The divider takes |d| * w in the cycle that it starts.
    assign w_ad   = (w_v < w_m) ? w_m - w_v : w_v - w_m;
    assign w_dnum = 64'(w_ad) * 64'(r_w);

    // The result moves into the output register once that is free or being emptied.
    assign w_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    // While idle the memory is addressed by the incoming sample, so that the entry is
    // ready in the cycle after the transfer.
    assign w_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign w_maddr = (r_state == S_CLEAR) ? r_clr :
                     (r_state == S_IDLE)  ? w_idx[AW-1:0] : r_addr;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : r_ent;

    pwrv_ram #(.WIDTH(pwrv_pkg::ENTRY_W), .DEPTH(pwrv_pkg::DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_maddr),
        .i_wdata(w_wdata), .o_rdata(w_rd)
    );

    pwrv_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_DIFF && r_snew != '0),
        .i_num({8'd0, w_dnum}), .i_den(r_snew),
        .o_ctl(w_dctl), .o_quo(w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(pwrv_pkg::DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_DIFF;
            S_DIFF:  n_state = (r_snew == '0) ? S_UPD : S_DIV;
            S_DIV:   if (w_dctl.done) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2A;
            S_MUL2A: n_state = S_MUL2B;
            S_MUL2B: n_state = S_UPD;
            S_UPD:   n_state = (r_ch == 2'd2) ? S_WRITE : S_DIFF;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output register: holds one finished result while the next item is worked on.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_opix <= r_addr;
            r_oent <= r_ent;
        end
    end

    // Datapath; the entry is held in r_ent between read and write-back.
    always_ff @(posedge i_clk) begin
        logic [31:0] ar;
        logic [40:0] fsum;
        logic [48:0] ssum;
        logic [47:0] inc;
        logic [63:0] dep;
        logic [111:0] full;
        ar = 32'(w_quo);
        dep = (64'(r_w) * 64'(w_v)) >> 16;
        case (r_state)
            S_IDLE: begin
                r_addr <= w_idx[AW-1:0];
                r_w    <= i_weight;
                r_val[0] <= i_value_r;
                r_val[1] <= i_value_g;
                r_val[2] <= i_value_b;
                r_ch   <= 2'd0;
            end
            S_READ: begin
                r_ent  <= w_rd;
                r_snew <= w_ssum[40] ? '1 : w_ssum[39:0];
            end
            S_DIFF: begin
                r_neg <= w_v < w_m;
                r_ad  <= w_ad;
                r_plo <= dep;
            end
            S_MUL1: begin
                if (w_quo > 72'(r_ad)) ar = r_ad;
                r_ar <= ar;
                r_dr <= 64'(r_ad) * 64'(ar);
            end
            S_MUL2A: r_phi <= 64'(r_dr[31:0]) * 64'(r_ent.wgt[31:0]);
            S_MUL2B: begin
                r_dr  <= 64'(r_dr[63:32]) * 64'(r_ent.wgt[31:0]);
                r_pmh <= 72'(r_dr) * 72'(r_ent.wgt[39:32]);
            end
            S_UPD: begin
                fsum = 41'(r_ent.ch[r_ch].rad) + 41'(r_plo);
                r_ent.ch[r_ch].rad <= (fsum[40] || r_plo[63:40] != '0) ? '1 : fsum[39:0];
                if (r_snew != '0) begin
                    // inc = (ad*ar*S_old) >> 32, with S_old 40 bits in two parts.
                    full = (112'(r_dr) << 32) + 112'(r_phi) + (112'(r_pmh) << 32);
                    inc = (full[111:80] != '0) ? '1 : full[79:32];
                    ssum = 49'(r_ent.ch[r_ch].spr) + 49'(inc);
                    r_ent.ch[r_ch].spr  <= ssum[48] ? '1 : ssum[47:0];
                    r_ent.ch[r_ch].mean <= r_neg ? w_m - r_ar : w_m + r_ar;
                end
                r_ch <= r_ch + 1'b1;
            end
            S_WRITE: r_ent.wgt <= r_ent.wgt;
            default: ;
        endcase
        if (r_state == S_UPD && r_ch == 2'd2) r_ent.wgt <= r_snew;
    end

    assign o_valid        = r_ovalid;
    assign o_pixel_index  = r_opix;
    assign o_radiance_r   = r_oent.ch[0].rad;
    assign o_radiance_g   = r_oent.ch[1].rad;
    assign o_radiance_b   = r_oent.ch[2].rad;
    assign o_average_r    = r_oent.ch[0].mean;
    assign o_average_g    = r_oent.ch[1].mean;
    assign o_average_b    = r_oent.ch[2].mean;
    assign o_spread_r     = r_oent.ch[0].spr;
    assign o_spread_g     = r_oent.ch[1].spr;
    assign o_spread_b     = r_oent.ch[2].spr;
    assign o_total_weight = r_oent.wgt;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_opix) && $stable(r_oent)))
        else $error("waiting result changed before its transfer");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dctl.done |-> r_state == S_DIV) else $error("divider finished out of step");
endmodule

// File: tb/pixel_weighted_running_variance_tb.sv
// Self-checking testbench for pixel_weighted_running_variance.
// Depends on pwrv_pkg and the block itself; holds its own fixed-point predictor of the per-pixel
// weighted running statistics.
`timescale 1ns / 100ps

module pixel_weighted_running_variance_tb;

    localparam longint unsigned RAD_MAX  = 64'hFF_FFFF_FFFF;
    localparam longint unsigned SPR_MAX  = 64'hFFFF_FFFF_FFFF;
    localparam int              CYCLE_LIMIT = 3_000_000;
    localparam int              DRAIN_CYCLES = 300;

    // One film sample as presented on the input channel.
    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
        logic [31:0] w;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
    } t_sample;

    // The updated pixel statistics that the block reports for one sample.
    typedef struct packed {
        logic [15:0] idx;
        logic [39:0] rad_r, rad_g, rad_b;
        logic [31:0] avg_r, avg_g, avg_b;
        logic [47:0] spr_r, spr_g, spr_b;
        logic [39:0] wsum;
    } t_pixel_stats;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_sample_u;
    logic [15:0] i_sample_v;
    logic [31:0] i_weight;
    logic [31:0] i_value_r;
    logic [31:0] i_value_g;
    logic [31:0] i_value_b;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_pixel_index;
    logic [39:0] o_radiance_r, o_radiance_g, o_radiance_b;
    logic [31:0] o_average_r, o_average_g, o_average_b;
    logic [47:0] o_spread_r, o_spread_g, o_spread_b;
    logic [39:0] o_total_weight;

    pixel_weighted_running_variance i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_u     (i_sample_u),
        .i_sample_v     (i_sample_v),
        .i_weight       (i_weight),
        .i_value_r      (i_value_r),
        .i_value_g      (i_value_g),
        .i_value_b      (i_value_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_index  (o_pixel_index),
        .o_radiance_r   (o_radiance_r),
        .o_radiance_g   (o_radiance_g),
        .o_radiance_b   (o_radiance_b),
        .o_average_r    (o_average_r),
        .o_average_g    (o_average_g),
        .o_average_b    (o_average_b),
        .o_spread_r     (o_spread_r),
        .o_spread_g     (o_spread_g),
        .o_spread_b     (o_spread_b),
        .o_total_weight (o_total_weight)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The predictor's own copy of the pixel memory, cleared as the block is after reset.
    bit [39:0] film_r [pwrv_pkg::DEPTH];
    bit [39:0] film_g [pwrv_pkg::DEPTH];
    bit [39:0] film_b [pwrv_pkg::DEPTH];
    bit [31:0] mean_r [pwrv_pkg::DEPTH];
    bit [31:0] mean_g [pwrv_pkg::DEPTH];
    bit [31:0] mean_b [pwrv_pkg::DEPTH];
    bit [47:0] m2_r [pwrv_pkg::DEPTH];
    bit [47:0] m2_g [pwrv_pkg::DEPTH];
    bit [47:0] m2_b [pwrv_pkg::DEPTH];
    bit [39:0] wsum_mem [pwrv_pkg::DEPTH];

    t_sample      pending_samples[$];
    t_pixel_stats expected_stats[$];
    bit           mismatch_seen = 1'b0;
    int           cycle_count = 0;

    // West's weighted update of one colour channel. The radiance sum takes the weighted
    // deposit and saturates at 40 bits. When the new weight sum is zero the mean and the
    // spread are left alone, since the rule would otherwise divide by zero.
    function automatic void blend_channel(input bit [31:0] val, input bit [31:0] w,
                                          input bit [39:0] s_old, input bit [39:0] s_new,
                                          inout bit [39:0] rad, inout bit [31:0] mean,
                                          inout bit [47:0] m2);
        bit [63:0]  deposit;
        bit [63:0]  rad_sum;
        bit         below;
        bit [31:0]  abs_dev;
        bit [63:0]  step;
        bit [127:0] prod;
        bit [47:0]  incr;
        bit [48:0]  m2_sum;
        deposit = (64'(w) * 64'(val)) >> 16;
        rad_sum = 64'(rad) + deposit;
        rad = (rad_sum > RAD_MAX) ? 40'(RAD_MAX) : rad_sum[39:0];
        if (s_new != 40'd0) begin
            below   = val < mean;
            abs_dev = below ? mean - val : val - mean;
            step    = (64'(abs_dev) * 64'(w)) / 64'(s_new);
            if (step > 64'(abs_dev))
                step = 64'(abs_dev);
            mean = below ? mean - step[31:0] : mean + step[31:0];
            // The product of |d| and |R| is kept to 64 bits, as the fixed-point rule does,
            // before it is scaled by the old weight sum.
            prod   = 128'(64'(abs_dev) * step) * 128'(s_old);
            incr   = (prod >= (128'd1 << 80)) ? 48'(SPR_MAX) : prod[79:32];
            m2_sum = 49'(m2) + 49'(incr);
            m2 = m2_sum[48] ? 48'(SPR_MAX) : m2_sum[47:0];
        end
    endfunction

    // Column or row of a Q0.16 fraction, clamped to the last one.
    function automatic int pick_col_row(input bit [15:0] frac, input int size);
        int c;
        c = int'((longint'(frac) * size) >>> 16);
        return (c > size - 1) ? size - 1 : c;
    endfunction

    // Works out the pixel's new statistics for one accepted sample and updates the copy.
    function automatic t_pixel_stats accumulate_sample(input t_sample s);
        t_pixel_stats res;
        bit [15:0]    pix;
        bit [39:0]    s_old;
        bit [40:0]    s_sum;
        bit [39:0]    s_new;
        pix   = 16'(32'(pick_col_row(s.v, pwrv_pkg::IMAGE_HEIGHT)) * pwrv_pkg::IMAGE_WIDTH
                    + 32'(pick_col_row(s.u, pwrv_pkg::IMAGE_WIDTH)));
        s_old = wsum_mem[pix];
        s_sum = 41'(s_old) + 41'(s.w);
        s_new = s_sum[40] ? 40'(RAD_MAX) : s_sum[39:0];
        blend_channel(s.r, s.w, s_old, s_new, film_r[pix], mean_r[pix], m2_r[pix]);
        blend_channel(s.g, s.w, s_old, s_new, film_g[pix], mean_g[pix], m2_g[pix]);
        blend_channel(s.b, s.w, s_old, s_new, film_b[pix], mean_b[pix], m2_b[pix]);
        wsum_mem[pix] = s_new;
        res.idx   = pix;
        res.rad_r = film_r[pix];
        res.rad_g = film_g[pix];
        res.rad_b = film_b[pix];
        res.avg_r = mean_r[pix];
        res.avg_g = mean_g[pix];
        res.avg_b = mean_b[pix];
        res.spr_r = m2_r[pix];
        res.spr_g = m2_g[pix];
        res.spr_b = m2_b[pix];
        res.wsum  = s_new;
        return res;
    endfunction

    function automatic void queue_sample(input bit [15:0] u, input bit [15:0] v,
                                         input bit [31:0] w, input bit [31:0] r,
                                         input bit [31:0] g, input bit [31:0] b);
        t_sample s;
        s = '{u: u, v: v, w: w, r: r, g: g, b: b};
        pending_samples = {pending_samples, s};
    endfunction

    // Position that lands on a given pixel with random sub-pixel offset (256 x 256 image).
    function automatic bit [15:0] pos_of(input int c);
        return 16'((c << 8) | $urandom_range(0, 255));
    endfunction

    // Sender: bursts of random length separated by random gaps. The predictor is run on
    // each transfer here, so expectations are queued in the order the block takes them.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_sample      nxt;
        logic         send_next;
        t_pixel_stats pred;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_sample_u <= '0;
            i_sample_v <= '0;
            i_weight   <= '0;
            i_value_r  <= '0;
            i_value_g  <= '0;
            i_value_b  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            send_next = 1'b0;
            if (i_valid && o_ready) begin
                pred = accumulate_sample({i_sample_u, i_sample_v, i_weight,
                                          i_value_r, i_value_g, i_value_b});
                expected_stats = {expected_stats, pred};
            end
            if (i_valid && !o_ready) begin
                // Holding the current transfer until it is taken.
                send_next = 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_samples.size() > 0) begin
                nxt = pending_samples.pop_front();
                i_sample_u <= nxt.u;
                i_sample_v <= nxt.v;
                i_weight   <= nxt.w;
                i_value_r  <= nxt.r;
                i_value_g  <= nxt.g;
                i_value_b  <= nxt.b;
                send_next = 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= int'($urandom_range(1, 8));
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                                              : int'($urandom_range(1, 300));
                end
            end
            i_valid <= send_next;
        end
    end

    // Receiver: runs in stretches, each picked at random as constant readiness or as
    // random stalls.
    int stall_phase_cycles;
    bit stall_mode;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready            <= 1'b0;
            stall_phase_cycles <= 0;
            stall_mode         <= 1'b0;
        end else begin
            if (stall_phase_cycles == 0) begin
                stall_phase_cycles <= int'($urandom_range(200, 3000));
                stall_mode         <= 1'($urandom_range(0, 1));
            end else begin
                stall_phase_cycles <= stall_phase_cycles - 1;
            end
            i_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // Monitor: every result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel_stats exp_s;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_stats.size() == 0) begin
                $error("result transfer with no expectation, pixel_index %0d", o_pixel_index);
                mismatch_seen = 1'b1;
            end else begin
                exp_s = expected_stats.pop_front();
                if (o_pixel_index !== exp_s.idx) begin
                    $error("pixel_index: expected %0h, got %0h", exp_s.idx, o_pixel_index);
                    mismatch_seen = 1'b1;
                end
                if (o_radiance_r !== exp_s.rad_r) begin
                    $error("radiance_r: expected %0h, got %0h", exp_s.rad_r, o_radiance_r);
                    mismatch_seen = 1'b1;
                end
                if (o_radiance_g !== exp_s.rad_g) begin
                    $error("radiance_g: expected %0h, got %0h", exp_s.rad_g, o_radiance_g);
                    mismatch_seen = 1'b1;
                end
                if (o_radiance_b !== exp_s.rad_b) begin
                    $error("radiance_b: expected %0h, got %0h", exp_s.rad_b, o_radiance_b);
                    mismatch_seen = 1'b1;
                end
                if (o_average_r !== exp_s.avg_r) begin
                    $error("average_r: expected %0h, got %0h", exp_s.avg_r, o_average_r);
                    mismatch_seen = 1'b1;
                end
                if (o_average_g !== exp_s.avg_g) begin
                    $error("average_g: expected %0h, got %0h", exp_s.avg_g, o_average_g);
                    mismatch_seen = 1'b1;
                end
                if (o_average_b !== exp_s.avg_b) begin
                    $error("average_b: expected %0h, got %0h", exp_s.avg_b, o_average_b);
                    mismatch_seen = 1'b1;
                end
                if (o_spread_r !== exp_s.spr_r) begin
                    $error("spread_r: expected %0h, got %0h", exp_s.spr_r, o_spread_r);
                    mismatch_seen = 1'b1;
                end
                if (o_spread_g !== exp_s.spr_g) begin
                    $error("spread_g: expected %0h, got %0h", exp_s.spr_g, o_spread_g);
                    mismatch_seen = 1'b1;
                end
                if (o_spread_b !== exp_s.spr_b) begin
                    $error("spread_b: expected %0h, got %0h", exp_s.spr_b, o_spread_b);
                    mismatch_seen = 1'b1;
                end
                if (o_total_weight !== exp_s.wsum) begin
                    $error("total_weight: expected %0h, got %0h", exp_s.wsum, o_total_weight);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Watchdog over the whole run, which includes the clearing pass after reset.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int hot_x;
        int hot_y;
        int pick;
        int n;

        // Directed samples. A zero weight on a fresh pixel leaves the weight sum at zero,
        // so the mean and spread must stay untouched.
        queue_sample(16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0);
        // First real sample at the same pixel, then a lower value to drive the deviation
        // negative, then a zero weight on a pixel that already holds weight.
        queue_sample(16'h0000, 16'h0000, 32'h0001_0000, 32'h0010_0000, 32'h0, 32'hFFFF_FFFF);
        queue_sample(16'h00FF, 16'h00FF, 32'h0003_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000);
        queue_sample(16'h0010, 16'h0020, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // The largest position in both axes, the other corners and the centre.
        queue_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
        queue_sample(16'hFFFF, 16'h0000, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF);
        queue_sample(16'h0000, 16'hFFFF, 32'h8000_0000, 32'h0, 32'h0000_0001, 32'h7FFF_FFFF);
        queue_sample(16'h8000, 16'h8000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                     32'h0003_0000);
        // Radiance saturation: the largest weight times the largest value, twice.
        queue_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        queue_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        // Tiny weight against a large sum, so the mean step rounds to zero.
        queue_sample(16'hFFFF, 16'hFFFF, 32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF);
        // Large spread growth: swings between the extremes at one pixel.
        for (n = 0; n < 6; n++)
            queue_sample(16'h4000, 16'hC000, 32'hFFFF_FFFF, (n % 2) ? 32'hFFFF_FFFF : 32'h0,
                         (n % 2) ? 32'h0 : 32'hFFFF_FFFF, 32'hAAAA_5555);

        // Random samples. Most land on one heavily weighted pixel so that the weight sum
        // and the spread reach saturation; the rest go to a handful of busy pixels or
        // anywhere in the image, some of them with zero weight.
        hot_x = $urandom_range(0, 255);
        hot_y = $urandom_range(0, 255);
        for (n = 0; n < 530; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                queue_sample(pos_of(hot_x), pos_of(hot_y), $urandom | 32'hC000_0000,
                             $urandom, $urandom, $urandom);
            else if (pick < 85)
                queue_sample(pos_of($urandom_range(0, 3)), pos_of($urandom_range(250, 255)),
                             ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom,
                             $urandom, $urandom, $urandom_range(0, 32'h0010_0000));
            else
                queue_sample(16'($urandom), 16'($urandom), $urandom >> $urandom_range(0, 31),
                             $urandom, $urandom, $urandom);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every sample to be taken and every result to be checked.
        do
            @(posedge i_clk);
        while (pending_samples.size() != 0 || i_valid || expected_stats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!mismatch_seen) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
